>>> hdl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    // Fixed field widths of the stream payload
    localparam int DATA_W     = 32;
    localparam int OUT_PRIO_W = 8;
    localparam int FILL_W     = 5;

    // Operation codes carried on the input tuser bit
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    // One result item, sequencer to output register
    typedef struct packed {
        logic [FILL_W-1:0]     fill_count;
        status_t               status;
        logic [OUT_PRIO_W-1:0] out_priority;
        logic [DATA_W-1:0]     out_data;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/spq_store.sv
`default_nettype none

module spq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 40
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/spq_seq.sv
`default_nettype none

module spq_seq #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // Item side
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic                                    in_action,
    input  wire logic [spq_pkg::DATA_W-1:0]              in_data,
    input  wire logic [spq_pkg::OUT_PRIO_W-1:0]          in_prio,
    // Result side
    output logic                                         res_valid,
    input  wire logic                                    res_ready,
    output spq_pkg::result_t                             res,
    // Entry memory
    output logic                                         mem_we,
    output logic [$clog2(DEPTH)-1:0]                     mem_waddr,
    output logic [PRIO_BITS+spq_pkg::DATA_W-1:0]         mem_wdata,
    output logic [$clog2(DEPTH)-1:0]                     mem_raddr,
    input  wire logic [PRIO_BITS+spq_pkg::DATA_W-1:0]    mem_rdata
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int DATA_W  = spq_pkg::DATA_W;
    localparam int OPRIO_W = spq_pkg::OUT_PRIO_W;
    localparam int FILL_W  = spq_pkg::FILL_W;

    spq_pkg::state_t      state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic [ADDR_W-1:0]    best_idx_reg, best_idx_next;
    logic [PRIO_BITS-1:0] best_prio_reg, best_prio_next;
    logic [DATA_W-1:0]    best_data_reg, best_data_next;
    logic [DATA_W-1:0]    res_data_reg, res_data_next;
    logic [PRIO_BITS-1:0] res_prio_reg, res_prio_next;
    spq_pkg::status_t     res_status_reg, res_status_next;

    logic [PRIO_BITS+OPRIO_W-1:0] prio_in_ext;
    logic [PRIO_BITS-1:0]         prio_in;
    logic [PRIO_BITS-1:0]         rd_prio;
    logic [DATA_W-1:0]            rd_data;
    logic                         take;
    logic [ADDR_W-1:0]            scan_best_idx;
    logic [PRIO_BITS-1:0]         scan_best_prio;
    logic [DATA_W-1:0]            scan_best_data;
    logic [CNT_W-1:0]             idx_ext;
    logic [CNT_W-1:0]             idx_p1;
    logic [CNT_W-1:0]             idx_p2;
    logic [CNT_W-1:0]             best_p1;
    logic                         scan_last;
    logic                         shift_last;
    logic                         is_full;
    logic [CNT_W+FILL_W-1:0]      fill_ext;
    logic [PRIO_BITS+OPRIO_W-1:0] prio_out_ext;

    // Input priority masked or extended to the stored width
    assign prio_in_ext = {{PRIO_BITS{1'b0}}, in_prio};
    assign prio_in     = prio_in_ext[PRIO_BITS-1:0];

    assign rd_prio = mem_rdata[PRIO_BITS+DATA_W-1:DATA_W];
    assign rd_data = mem_rdata[DATA_W-1:0];

    // Running minimum: strictly smaller wins, so the oldest slot keeps ties
    assign take           = (idx_reg == '0) || (rd_prio < best_prio_reg);
    assign scan_best_idx  = take ? idx_reg : best_idx_reg;
    assign scan_best_prio = take ? rd_prio : best_prio_reg;
    assign scan_best_data = take ? rd_data : best_data_reg;

    assign idx_ext    = {1'b0, idx_reg};
    assign idx_p1     = idx_ext + CNT_W'(1);
    assign idx_p2     = idx_ext + CNT_W'(2);
    assign best_p1    = {1'b0, scan_best_idx} + CNT_W'(1);
    assign scan_last  = (idx_p1 == count_reg);
    assign shift_last = (idx_p2 == count_reg);
    assign is_full    = (count_reg == CNT_W'(DEPTH));

    // Next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_data_next  = best_data_reg;
        res_data_next   = res_data_reg;
        res_prio_next   = res_prio_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_data_next = '0;
                    res_prio_next = '0;
                    if (in_action == spq_pkg::ACT_ENQ)
                    begin
                        state_next = spq_pkg::ST_EMIT;
                        if (is_full)
                        begin
                            res_status_next = spq_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            count_next      = count_reg + CNT_W'(1);
                            res_status_next = spq_pkg::STATUS_OK;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next      = spq_pkg::ST_EMIT;
                        res_status_next = spq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        state_next = spq_pkg::ST_SCAN;
                        idx_next   = '0;
                    end
                end
            end
            spq_pkg::ST_SCAN:
            begin
                best_idx_next  = scan_best_idx;
                best_prio_next = scan_best_prio;
                best_data_next = scan_best_data;
                if (scan_last)
                begin
                    if (best_p1 == count_reg)
                    begin
                        // winner is the newest entry: nothing to close up
                        state_next      = spq_pkg::ST_EMIT;
                        count_next      = count_reg - CNT_W'(1);
                        res_data_next   = scan_best_data;
                        res_prio_next   = scan_best_prio;
                        res_status_next = spq_pkg::STATUS_OK;
                    end
                    else
                    begin
                        state_next = spq_pkg::ST_SHIFT;
                        idx_next   = scan_best_idx;
                    end
                end
                else
                begin
                    idx_next = idx_p1[ADDR_W-1:0];
                end
            end
            spq_pkg::ST_SHIFT:
            begin
                if (shift_last)
                begin
                    state_next      = spq_pkg::ST_EMIT;
                    count_next      = count_reg - CNT_W'(1);
                    res_data_next   = best_data_reg;
                    res_prio_next   = best_prio_reg;
                    res_status_next = spq_pkg::STATUS_OK;
                end
                else
                begin
                    idx_next = idx_p1[ADDR_W-1:0];
                end
            end
            spq_pkg::ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: handshakes and memory port control
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = mem_rdata;
        mem_raddr = '0;
        case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                mem_we    = in_valid && (in_action == spq_pkg::ACT_ENQ) && !is_full;
                mem_waddr = count_reg[ADDR_W-1:0];
                mem_wdata = {prio_in, in_data};
            end
            spq_pkg::ST_SCAN:
            begin
                mem_raddr = scan_last ? best_p1[ADDR_W-1:0] : idx_p1[ADDR_W-1:0];
            end
            spq_pkg::ST_SHIFT:
            begin
                // move slot idx+1 down into slot idx, fetch the one after
                mem_we    = 1'b1;
                mem_raddr = idx_p2[ADDR_W-1:0];
            end
            spq_pkg::ST_EMIT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Result item; fill count follows the already updated entry count
    assign fill_ext         = {{FILL_W{1'b0}}, count_reg};
    assign prio_out_ext     = {{OPRIO_W{1'b0}}, res_prio_reg};
    assign res.out_data     = res_data_reg;
    assign res.out_priority = prio_out_ext[OPRIO_W-1:0];
    assign res.status       = res_status_reg;
    assign res.fill_count   = fill_ext[FILL_W-1:0];

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_data_reg  <= best_data_next;
        res_data_reg   <= res_data_next;
        res_prio_reg   <= res_prio_next;
        res_status_reg <= res_status_next;
    end

`ifndef SYNTHESIS
    // Entry count never runs past the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // A stored enqueue grows the count by one
    a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_action == spq_pkg::ACT_ENQ) && !is_full
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("enqueue did not advance count");

    // The close-up pass only moves entries out of live slots
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spq_pkg::ST_SHIFT) |-> (idx_p1 < count_reg))
        else $error("shift source beyond held entries");
`endif

endmodule

`default_nettype wire

>>> hdl/stable_min_priority_queue_unit.sv
`default_nettype none

// Channel   Dir  Signals                      Payload (lowest bit first)
// s_axis    in   tvalid tready tdata tuser    tdata: item_data, item_priority
//                                             tuser: action
// m_axis    out  tvalid tready tdata tuser    tdata: out_data, out_priority,
//                                                    fill_count
//                                             tuser: status
//
// An enqueue writes the next free slot. A dequeue scans the held entries
// for the minimum and moves any later entries down to close its gap: the
// single read port of the entry memory serves one slot per cycle for both.
// Reset clears the control state, entry count and output valid flag; the
// entry memory needs no clearing. One output register holds a finished
// result, so the next item is taken while it waits; a second result waits
// in the sequencer until it drains.
module stable_min_priority_queue_unit #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // item_data[31:0], item_priority[39:32]
    input  wire logic [0:0]  s_axis_tuser,   // action[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // out_data[31:0], out_priority[39:32],
                                             // fill_count[44:40], zero pad[47:45]
    output logic [1:0]       m_axis_tuser    // status[1:0]
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ENTRY_W = PRIO_BITS + spq_pkg::DATA_W;

    logic               res_valid;
    logic               res_ready;
    spq_pkg::result_t   res;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    logic               out_valid_reg, out_valid_next;
    spq_pkg::result_t   out_reg, out_next;

    spq_seq #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser[0]),
        .in_data   (s_axis_tdata[31:0]),
        .in_prio   (s_axis_tdata[39:32]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    spq_store #(
        .DEPTH (DEPTH),
        .WIDTH (ENTRY_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: loads when empty or being drained this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Master-side packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.fill_count, out_reg.out_priority, out_reg.out_data};
    assign m_axis_tuser  = out_reg.status;

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int QUEUE_DEPTH = 16;
    localparam int PRIO_W      = 8;
    // Worst dequeue: full scan plus full gap closing, with margin
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
    localparam int PHASES       = 22;
    localparam int PHASE_ITEMS  = 25;

    // One stored entry of the predictor
    typedef struct packed {
        logic [31:0] data;
        logic [7:0]  prio;
    } pq_entry_t;

    // One result, field by field
    typedef struct packed {
        logic [31:0]      data;
        logic [7:0]       prio;
        spq_pkg::status_t status;
        logic [4:0]       fill;
    } pq_result_t;

    // One row of the directed table
    typedef struct packed {
        logic        act;
        logic [31:0] data;
        logic [7:0]  prio;
        logic        typed;
        pq_result_t  want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // item_data[31:0], item_priority[39:32]
    logic [0:0]  s_axis_tuser;   // action[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // out_data[31:0], out_priority[39:32], fill_count[44:40]
    logic [1:0]  m_axis_tuser;   // status[1:0]

    pq_entry_t  held_entries[$];
    pq_result_t pending_results[$];
    stim_row_t  directed_rows[$];
    int         err_count;
    bit         tx_quiet;
    bit         rx_quiet;

    stable_min_priority_queue_unit #(
        .DEPTH     (QUEUE_DEPTH),
        .PRIO_BITS (PRIO_W)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Queue predictor: apply one operation, return the result it gives
    function automatic pq_result_t predict_queue_op(logic act, logic [31:0] d, logic [7:0] p);
        pq_result_t r;
        pq_entry_t  e;
        int         best;
        r        = '0;
        r.status = spq_pkg::STATUS_OK;
        if (act == spq_pkg::ACT_ENQ)
        begin
            if (held_entries.size() >= QUEUE_DEPTH)
                r.status = spq_pkg::STATUS_FULL;
            else
            begin
                e.data = d;
                e.prio = p;
                held_entries.push_back(e);
            end
        end
        else if (held_entries.size() == 0)
            r.status = spq_pkg::STATUS_EMPTY;
        else
        begin
            // strictly smaller wins, so the oldest of equal priorities is served
            best = 0;
            for (int i = 1; i < held_entries.size(); i++)
                if (held_entries[i].prio < held_entries[best].prio)
                    best = i;
            r.data = held_entries[best].data;
            r.prio = held_entries[best].prio;
            held_entries.delete(best);
        end
        r.fill = 5'(held_entries.size());
        return r;
    endfunction

    function automatic stim_row_t mk_row(logic act, logic [31:0] d, logic [7:0] p, logic typed,
                                         logic [31:0] wd, logic [7:0] wp,
                                         spq_pkg::status_t st, logic [4:0] fill);
        stim_row_t row;
        row.act         = act;
        row.data        = d;
        row.prio        = p;
        row.typed       = typed;
        row.want.data   = wd;
        row.want.prio   = wp;
        row.want.status = st;
        row.want.fill   = fill;
        return row;
    endfunction

    task automatic report_mismatch(string what, pq_result_t want, pq_result_t got);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] %s: expected data=%h prio=%h status=%0d fill=%0d,",
                     $time, what, want.data, want.prio, want.status, want.fill,
                     " got data=%h prio=%h status=%0d fill=%0d",
                     got.data, got.prio, got.status, got.fill);
    endtask

    // Drive one item, wait for its transfer, then record the expected result
    task automatic send_item(logic act, logic [31:0] d, logic [7:0] p, logic typed,
                             pq_result_t want);
        int         gap;
        pq_result_t pred;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p, d};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = predict_queue_op(act, d, p);
        pending_results.push_back(typed ? want : pred);
    endtask

    // Hold the input until every outstanding result has drained
    task automatic drain_pause();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int          enq_pct;
        int          prio_mode;
        logic        act;
        logic [7:0]  p;
        pq_result_t  none;

        err_count     = 0;
        tx_quiet      = 1'b0;
        none          = '0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= spq_pkg::ACT_ENQ;

        // Directed table: empty, extremes, ties, full, then the best entry first
        directed_rows.push_back(mk_row(spq_pkg::ACT_DEQ, 32'h0, 8'h00, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_EMPTY, 5'd0));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'h7FFFFFFF, 8'hFF, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd1));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'h80000000, 8'h00, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd2));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'hFFFFFFFF, 8'hFF, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd3));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'h00000000, 8'h80, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd4));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'h00000001, 8'h01, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd5));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'h55555555, 8'h10, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd6));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'hAAAAAAAA, 8'h00, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd7));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'h12345678, 8'h7F, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd8));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'h87654321, 8'h80, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd9));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'hFFFF0000, 8'h01, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd10));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'h0000FFFF, 8'hFE, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd11));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'h00000002, 8'h55, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd12));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'hC3C3C3C3, 8'hAA, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd13));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'h7FFFFFFE, 8'h00, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd14));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'h80000001, 8'h3C, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd15));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'h13579BDF, 8'hC3, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd16));
        directed_rows.push_back(mk_row(spq_pkg::ACT_ENQ, 32'hDEADBEEF, 8'h00, 1'b1,
                                       32'h0, 8'h00, spq_pkg::STATUS_FULL, 5'd16));
        directed_rows.push_back(mk_row(spq_pkg::ACT_DEQ, 32'h0, 8'h00, 1'b1,
                                       32'h80000000, 8'h00, spq_pkg::STATUS_OK, 5'd15));
        directed_rows.push_back(mk_row(spq_pkg::ACT_DEQ, 32'hFFFFFFFF, 8'hFF, 1'b0,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd0));
        directed_rows.push_back(mk_row(spq_pkg::ACT_DEQ, 32'h0, 8'h00, 1'b0,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd0));
        directed_rows.push_back(mk_row(spq_pkg::ACT_DEQ, 32'h0, 8'h00, 1'b0,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd0));
        directed_rows.push_back(mk_row(spq_pkg::ACT_DEQ, 32'h0, 8'h00, 1'b0,
                                       32'h0, 8'h00, spq_pkg::STATUS_OK, 5'd0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].act, directed_rows[i].data, directed_rows[i].prio,
                      directed_rows[i].typed, directed_rows[i].want);

        // Random phases: fill-heavy, drain-heavy or balanced, with varied priority spread
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 80;
                1:       enq_pct = 25;
                default: enq_pct = 55;
            endcase
            prio_mode = $urandom_range(0, 2);
            tx_quiet  = ($urandom_range(0, 3) == 0);
            if (ph == PHASES / 2 || $urandom_range(0, 7) == 0)
                drain_pause();
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                act = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::ACT_ENQ : spq_pkg::ACT_DEQ;
                case (prio_mode)
                    0:       p = 8'($urandom_range(0, 3));       // dense ties
                    1:       p = 8'($urandom_range(0, 255));
                    default: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                endcase
                send_item(act, $urandom, p, 1'b0, none);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Wait out the remaining results, then a quiet tail
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Receiver: random stalls per transfer, with stall-free stretches
    initial
    begin
        int stall;
        int n_rx;
        n_rx          = 0;
        rx_quiet      = 1'b0;
        m_axis_tready <= 1'b0;
        do
            @(posedge clk);
        while (rst_n !== 1'b1);
        forever
        begin
            if (n_rx % 32 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall = rx_quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            n_rx++;
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        pq_result_t got;
        pq_result_t want;
        if (rst_n === 1'b1 && m_axis_tvalid && m_axis_tready)
        begin
            got.data   = m_axis_tdata[31:0];
            got.prio   = m_axis_tdata[39:32];
            got.fill   = m_axis_tdata[44:40];
            got.status = spq_pkg::status_t'(m_axis_tuser);
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.data !== want.data || got.prio !== want.prio ||
                    got.status !== want.status || got.fill !== want.fill)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // Hang guard
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/spq_pkg.sv
hdl/spq_store.sv
hdl/spq_seq.sv
hdl/stable_min_priority_queue_unit.sv
bench/tb.sv
